// File: sv/bsfu_pkg.sv
// Package: shared types, constants and helpers for the byte-stuffed frame unpacker.
`timescale 1ns / 1ps
package bsfu_pkg;

    localparam int MAX_PACKET = 1024;
    localparam int LIMIT_CAP  = (MAX_PACKET > 1024) ? 1024 : MAX_PACKET;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam logic [2:0] ST_WAIT_SYNC  = 3'd0;
    localparam logic [2:0] ST_AFTER_FLAG = 3'd1;
    localparam logic [2:0] ST_AFTER_ESC  = 3'd2;
    localparam logic [2:0] ST_IN_MSG     = 3'd3;
    localparam logic [2:0] ST_COMPLETE   = 3'd4;

    localparam logic [1:0] CLS_DATA = 2'd0;
    localparam logic [1:0] CLS_FLAG = 2'd1;
    localparam logic [1:0] CLS_ESC  = 2'd2;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [10:0] MAX_LENGTH_RESET = 11'd1024;

    localparam logic [0:0] REG_MAX_LENGTH = 1'd0;

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     full;
        logic     empty;
        q_entry_t head;
    } q_status_t;

    typedef struct packed {
        logic [2:0] status;
        logic       byte_valid;
        logic [7:0] payload_byte;
        logic [9:0] byte_index;
        logic [9:0] frame_length;
        logic       frame_cancelled;
    } result_t;

    function automatic logic [10:0] eff_limit(input logic [10:0] max_length);
        logic [10:0] lim;
        lim = max_length;
        if (lim < 11'd1) lim = 11'd1;
        if (lim > 11'(LIMIT_CAP)) lim = 11'(LIMIT_CAP);
        return lim;
    endfunction

endpackage

// File: sv/byte_stuffed_frame_unpacker.sv
// Top level: byte-stuffed frame unpacker with APB configuration and item streams.
//
//   channel  | direction | contents
//   s_axis   | in        | one received byte per item
//   m_axis   | out       | one result item per received byte
//   apb      | in/out    | max_length register at byte address 0
//
// One item per cycle sustained while m_axis is ready; a byte passes from s_axis
// to m_axis through the queue write, then the state machine and result register.
// Reset (aresetn low, synchronous) clears the queue, state and count, and sets
// max_length back to 1024.
// A stall on m_axis fills the four-entry queue; s_axis_tready drops when it is full.
`timescale 1ns / 1ps
module byte_stuffed_frame_unpacker import bsfu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] byte_valid, [11:4] payload_byte, [21:12] byte_index,
    // [31:22] frame_length, [32] frame_cancelled, [39:33] zero
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0] max_length_reg, max_length_next;
    q_push_t     q_push;
    q_status_t   q_status;
    logic        pop;
    result_t     result;
    logic        reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_MAX_LENGTH);

    always_comb begin
        max_length_next = max_length_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            max_length_next = pwdata[10:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
        end else begin
            max_length_reg <= max_length_next;
        end
    end

    assign prdata = reg_hit ? {21'd0, max_length_reg} : 32'd0;

    bsfu_classify u_classify (
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_status.full),
        .q_push        (q_push)
    );

    bsfu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status)
    );

    bsfu_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_length    (max_length_reg),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .result        (result)
    );

    assign m_axis_tdata = {7'd0, result.frame_cancelled, result.frame_length,
                           result.byte_index, result.payload_byte,
                           result.byte_valid, result.status};

`ifndef NO_ASSERTIONS
    a_cancel_resyncs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && result.frame_cancelled) |->
        (result.byte_valid && result.status == ST_WAIT_SYNC && result.frame_length == 10'd0))
        else $error("cancel without resync");

    a_length_follows_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && result.byte_valid && !result.frame_cancelled) |->
        (result.frame_length == 10'(result.byte_index + 10'd1)))
        else $error("frame length does not follow byte index");

    a_complete_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && result.status == ST_COMPLETE) |-> !result.byte_valid)
        else $error("byte stored on closing flag");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !s_axis_tready)
        else $error("input accepted while queue full");
`endif

endmodule

// File: sv/bsfu_classify.sv
// Front end: accepts received bytes and tags each as flag, escape or data.
`timescale 1ns / 1ps
module bsfu_classify import bsfu_pkg::*; (
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       q_full,
    output q_push_t    q_push
);

    logic [1:0] cls;

    always_comb begin
        if (s_axis_tdata == FLAG_BYTE) begin
            cls = CLS_FLAG;
        end else if (s_axis_tdata == ESC_BYTE) begin
            cls = CLS_ESC;
        end else begin
            cls = CLS_DATA;
        end
    end

    assign s_axis_tready     = aresetn && !q_full;
    assign q_push.push       = s_axis_tvalid && s_axis_tready;
    assign q_push.entry.cls  = cls;
    assign q_push.entry.data = s_axis_tdata;

endmodule

// File: sv/bsfu_queue.sv
// Short item queue between the classifier and the deframing engine.
`timescale 1ns / 1ps
module bsfu_queue import bsfu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_push_t   q_push,
    input  logic      pop,
    output q_status_t q_status
);

    q_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_push.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_push.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            mem[wr_ptr_reg] <= q_push.entry;
        end
    end

    assign q_status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_status.head  = mem[rd_ptr_reg];

endmodule

// File: sv/bsfu_engine.sv
// Back end: frame state machine, payload counter and registered result item.
`timescale 1ns / 1ps
module bsfu_engine import bsfu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [10:0] max_length,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output result_t     result
);

    logic [2:0]  state_reg, state_next;
    logic [9:0]  count_reg, count_next;
    logic        valid_reg, valid_next;
    result_t     result_reg, result_next;

    logic [2:0]  st;
    logic [9:0]  cnt;
    logic        store;
    logic        cancel;
    logic [7:0]  data;
    logic [10:0] cnt_inc;
    logic [1:0]  cls;
    logic [7:0]  rx;

    assign pop = !q_status.empty && (!valid_reg || m_axis_tready);
    assign cls = q_status.head.cls;
    assign rx  = q_status.head.data;

    always_comb begin
        st     = state_reg;
        cnt    = count_reg;
        store  = 1'b0;
        cancel = 1'b0;
        data   = 8'd0;

        if (st == ST_COMPLETE) begin
            cnt = 10'd0;
            st  = ST_AFTER_FLAG;
        end

        case (st)
            ST_AFTER_FLAG: begin
                if (cls == CLS_FLAG) begin
                    st = ST_AFTER_FLAG;
                end else if (cls == CLS_ESC) begin
                    st = ST_AFTER_ESC;
                end else begin
                    st    = ST_IN_MSG;
                    store = 1'b1;
                    data  = rx;
                end
            end
            ST_AFTER_ESC: begin
                st    = ST_IN_MSG;
                store = 1'b1;
                data  = rx ^ ESC_XOR;
            end
            ST_IN_MSG: begin
                if (cls == CLS_FLAG) begin
                    st = ST_COMPLETE;
                end else if (cls == CLS_ESC) begin
                    st = ST_AFTER_ESC;
                end else begin
                    store = 1'b1;
                    data  = rx;
                end
            end
            default: begin
                st = (cls == CLS_FLAG) ? ST_AFTER_FLAG : ST_WAIT_SYNC;
            end
        endcase

        cnt_inc = {1'b0, cnt} + 11'd1;
        if (store && (cnt_inc >= eff_limit(max_length))) begin
            cancel = 1'b1;
            st     = ST_WAIT_SYNC;
        end

        result_next.status          = st;
        result_next.byte_valid      = store;
        result_next.payload_byte    = data;
        result_next.byte_index      = store ? cnt : 10'd0;
        result_next.frame_cancelled = cancel;
        if (cancel) begin
            result_next.frame_length = 10'd0;
        end else if (store) begin
            result_next.frame_length = cnt_inc[9:0];
        end else begin
            result_next.frame_length = cnt;
        end

        if (pop) begin
            state_next = st;
            count_next = result_next.frame_length;
            valid_next = 1'b1;
        end else begin
            state_next  = state_reg;
            count_next  = count_reg;
            valid_next  = valid_reg && !m_axis_tready;
            result_next = result_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT_SYNC;
            count_reg <= 10'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign result        = result_reg;

endmodule
